@@ rtl/core/twcg_pkg.sv @@
// Shared types and constants for the textured wall column generator.
`default_nettype none

package twcg_pkg;

   // Field widths
   localparam int ColW    = 11;
   localparam int RowW    = 12;
   localparam int BotW    = 13;
   localparam int ColorW  = 32;
   localparam int TexColW = 8;
   localparam int TexWidW = 9;
   localparam int Log2W   = 4;
   localparam int IndexW  = 16;
   localparam int DistW   = 32;
   localparam int PosW    = 32;

   // Fixed-point and setup constants
   localparam int FracW     = 16;
   localparam int StepNumW  = 25;   // 256 << 16 needs 25 bits
   localparam int NearLimit = 7;    // 0.0001 in 16.16
   localparam int NearScale = 10;   // 1 / 0.1
   localparam int MaxLog2   = 8;
   localparam int TrowW     = 8;

   typedef enum logic {
      REQ_SETUP = 1'b0,
      REQ_TICK  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      SRC_CEILING = 2'd0,
      SRC_WALL    = 2'd1,
      SRC_FLOOR   = 2'd2
   } source_type;

   typedef enum logic {
      CSR_CEILING = 1'b0,
      CSR_FLOOR   = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LH_START,
      ST_LH_WAIT,
      ST_STEP_START,
      ST_STEP_WAIT,
      ST_MUL
   } ctrl_state_type;

   typedef struct packed {
      logic load_setup;
      logic div_start;
      logic div_sel_step;
      logic load_lh;
      logic load_step;
      logic load_pos;
      logic tick_fire;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic column_active;
      logic out_hold;
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/core/twcg_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none

module twcg_div #(
   parameter int DIV_W = 26
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [31:0]      divisor,
   output logic                  done,
   output logic [DIV_W-1:0]      quotient
);
   import twcg_pkg::*;

   localparam int CntW = $clog2(DIV_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CntW-1:0]  cnt_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [31:0]      rem_ff;
   logic [31:0]      divisor_ff;
   logic [32:0]      rem_sh;
   logic [33:0]      diff;
   logic             fits;

   // Shift in the next dividend bit and trial-subtract
   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIV_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, divisor_ff};
      fits   = ~diff[33];
   end

   // Control: count iterations, pulse done
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntW'(DIV_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CntW'(1);
            if (cnt_ff == CntW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: remainder and quotient shift
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[31:0] : rem_sh[31:0];
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef ASSERT_OFF
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");
`endif

endmodule

`default_nettype wire

@@ rtl/core/twcg_dp.sv @@
// Datapath: column setup arithmetic, row walker and result register.
`default_nettype none

module twcg_dp #(
   parameter int SCREEN_HEIGHT = 512,
   parameter int DIV_W         = 26
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire twcg_pkg::dp_cmd_type        cmd,
   output twcg_pkg::dp_status_type          status,
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_index,
   input  wire logic [31:0]                 csr_wr_data,
   input  wire logic [twcg_pkg::ColW-1:0]    req_column_x,
   input  wire logic [twcg_pkg::DistW-1:0]   req_wall_distance,
   input  wire logic [twcg_pkg::TexColW-1:0] req_tex_column,
   input  wire logic [twcg_pkg::TexWidW-1:0] req_tex_width,
   input  wire logic [twcg_pkg::Log2W-1:0]   req_tex_height_log2,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [twcg_pkg::ColW-1:0]         rsp_pixel_x,
   output logic [twcg_pkg::RowW-1:0]         rsp_pixel_y,
   output logic [1:0]                       rsp_source,
   output logic [twcg_pkg::ColorW-1:0]       rsp_flat_color,
   output logic [twcg_pkg::IndexW-1:0]       rsp_texel_index,
   output logic                             rsp_last
);
   import twcg_pkg::*;

   localparam logic [DIV_W-1:0] HalfW     = DIV_W'(SCREEN_HEIGHT / 2);
   localparam logic [DIV_W-1:0] ScreenW   = DIV_W'(SCREEN_HEIGHT);
   localparam logic [DIV_W-1:0] NearLh    = DIV_W'(SCREEN_HEIGHT * NearScale);
   localparam logic [DIV_W-1:0] HeightNum = DIV_W'(SCREEN_HEIGHT) << FracW;
   localparam logic [RowW-1:0]  RowLast   = RowW'(SCREEN_HEIGHT - 1);
   localparam logic [BotW-1:0]  BotMax    = BotW'(SCREEN_HEIGHT);

   // Configuration registers
   logic [ColorW-1:0]  ceiling_ff;
   logic [ColorW-1:0]  floor_ff;

   // Column state
   logic               active_ff;
   logic [RowW-1:0]    row_ff;
   logic               near_ff;
   logic [DistW-1:0]   dist_ff;
   logic [ColW-1:0]    col_ff;
   logic [TexColW-1:0] tex_col_ff;
   logic [TexWidW-1:0] tex_wid_ff;
   logic [Log2W-1:0]   log2_ff;
   logic [Log2W-1:0]   log2_in;
   logic [DIV_W-1:0]   lh_ff;
   logic [DIV_W-1:0]   lh_in;
   logic [DIV_W-1:0]   lh_half;
   logic [RowW-1:0]    top_ff;
   logic [RowW-1:0]    top_in;
   logic [BotW-1:0]    bot_ff;
   logic [BotW-1:0]    bot_in;
   logic [DIV_W:0]     bot_sum;
   logic [DIV_W-1:0]   offset_ff;
   logic [DIV_W-1:0]   offset_in;
   logic [PosW-1:0]    step_ff;
   logic [PosW-1:0]    pos_ff;
   logic [PosW-1:0]    pos_mul;

   // Divider hookup
   logic [DIV_W-1:0]   div_dividend;
   logic [31:0]        div_divisor;
   logic               div_done;
   logic [DIV_W-1:0]   div_quotient;

   // Row decision
   logic               is_wall;
   logic               is_ceil;
   logic [TrowW-1:0]   tex_mask;
   logic [TrowW-1:0]   trow;
   logic [IndexW-1:0]  texel_in;
   source_type         source_in;
   logic [ColorW-1:0]  color_in;

   // Result register
   logic               rsp_valid_ff;
   logic [ColW-1:0]    rsp_x_ff;
   logic [RowW-1:0]    rsp_y_ff;
   source_type         rsp_source_ff;
   logic [ColorW-1:0]  rsp_color_ff;
   logic [IndexW-1:0]  rsp_index_ff;
   logic               rsp_last_ff;

   twcg_div #(
      .DIV_W(DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Select divider operands: line height first, then texture step
   always_comb begin
      if (cmd.div_sel_step) begin
         div_dividend = DIV_W'(1) << (5'(FracW) + {1'b0, log2_ff});
         div_divisor  = (lh_ff == '0) ? 32'd1 : 32'(lh_ff);
      end else begin
         div_dividend = HeightNum;
         div_divisor  = dist_ff;
      end
   end

   // Clamp wall extent and texture offset from the line height
   always_comb begin
      log2_in   = (req_tex_height_log2 > Log2W'(MaxLog2)) ? Log2W'(MaxLog2)
                                                          : req_tex_height_log2;
      lh_in     = near_ff ? NearLh : div_quotient;
      lh_half   = lh_in >> 1;
      top_in    = (lh_half >= HalfW) ? '0 : RowW'(HalfW - lh_half);
      bot_sum   = {1'b0, HalfW} + {1'b0, lh_half};
      bot_in    = (bot_sum >= {1'b0, ScreenW}) ? BotMax : BotW'(bot_sum);
      offset_in = (lh_half >= HalfW) ? (lh_half - HalfW) : '0;
      pos_mul   = PosW'(offset_ff) * step_ff;
   end

   // Classify the current row and build the pixel
   always_comb begin
      is_wall  = (row_ff >= top_ff) && ({1'b0, row_ff} <= bot_ff);
      is_ceil  = row_ff < top_ff;
      tex_mask = TrowW'((9'd1 << log2_ff) - 9'd1);
      trow     = pos_ff[FracW +: TrowW] & tex_mask;
      texel_in = '0;
      color_in = '0;
      if (is_wall) begin
         source_in = SRC_WALL;
         texel_in  = IndexW'(17'(trow) * 17'(tex_wid_ff) + 17'(tex_col_ff));
      end else if (is_ceil) begin
         source_in = SRC_CEILING;
         color_in  = ceiling_ff;
      end else begin
         source_in = SRC_FLOOR;
         color_in  = floor_ff;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff <= '0;
         floor_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_CEILING: ceiling_ff <= csr_wr_data;
            CSR_FLOOR:   floor_ff   <= csr_wr_data;
            default:     ;
         endcase
      end
   end

   // Column control: activate after setup, advance per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         row_ff    <= '0;
      end else if (cmd.load_setup) begin
         active_ff <= 1'b0;
      end else if (cmd.load_pos) begin
         active_ff <= 1'b1;
         row_ff    <= '0;
      end else if (cmd.tick_fire) begin
         if (row_ff >= RowLast) begin
            active_ff <= 1'b0;
            row_ff    <= '0;
         end else begin
            row_ff <= row_ff + RowW'(1);
         end
      end
   end

   // Column payload: hold setup fields and derived values
   always_ff @(posedge clock) begin
      if (cmd.load_setup) begin
         near_ff    <= req_wall_distance < DistW'(NearLimit);
         dist_ff    <= req_wall_distance;
         col_ff     <= req_column_x;
         tex_col_ff <= req_tex_column;
         tex_wid_ff <= req_tex_width;
         log2_ff    <= log2_in;
      end
      if (cmd.load_lh) begin
         lh_ff     <= lh_in;
         top_ff    <= top_in;
         bot_ff    <= bot_in;
         offset_ff <= offset_in;
      end
      if (cmd.load_step) begin
         step_ff <= PosW'(div_quotient);
      end
      if (cmd.load_pos) begin
         pos_ff <= pos_mul;
      end else if (cmd.tick_fire && is_wall) begin
         pos_ff <= pos_ff + step_ff;
      end
   end

   // Result register: load on tick, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.tick_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick_fire) begin
         rsp_x_ff      <= col_ff;
         rsp_y_ff      <= row_ff;
         rsp_source_ff <= source_in;
         rsp_color_ff  <= color_in;
         rsp_index_ff  <= texel_in;
         rsp_last_ff   <= row_ff == RowLast;
      end
   end

   assign status.div_done      = div_done;
   assign status.column_active = active_ff;
   assign status.out_hold      = rsp_valid_ff & rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_source      = rsp_source_ff;
   assign rsp_flat_color  = rsp_color_ff;
   assign rsp_texel_index = rsp_index_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_fire |-> !(rsp_valid_ff && rsp_stall))
      else $error("pixel overwrote a stalled beat");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (row_ff <= RowLast))
      else $error("row counter past last row");

   a_column_start: assert property (@(posedge clock) disable iff (reset)
      cmd.load_pos |=> (active_ff && row_ff == '0))
      else $error("column did not start at row zero");
`endif

endmodule

`default_nettype wire

@@ rtl/core/twcg_ctrl.sv @@
// Controller: sequences column setup and issues row ticks.
`default_nettype none

module twcg_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire twcg_pkg::req_kind_type  req_type,
   input  wire twcg_pkg::dp_status_type status,
   output logic                      req_stall,
   output twcg_pkg::dp_cmd_type      cmd
);
   import twcg_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           accept;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE) | status.out_hold;
      accept    = req_valid & ~req_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_SETUP) begin
                  cmd.load_setup = 1'b1;
                  state_in       = ST_LH_START;
               end else if (status.column_active) begin
                  cmd.tick_fire = 1'b1;
               end
            end
         end
         ST_LH_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_LH_WAIT;
         end
         ST_LH_WAIT: begin
            if (status.div_done) begin
               cmd.load_lh = 1'b1;
               state_in    = ST_STEP_START;
            end
         end
         ST_STEP_START: begin
            cmd.div_start    = 1'b1;
            cmd.div_sel_step = 1'b1;
            state_in         = ST_STEP_WAIT;
         end
         ST_STEP_WAIT: begin
            if (status.div_done) begin
               cmd.load_step = 1'b1;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.load_pos = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_LH_WAIT || state_ff == ST_STEP_WAIT))
      else $error("divider finished outside a wait state");
`endif

endmodule

`default_nettype wire

@@ rtl/core/textured_wall_column_generator_unit.sv @@
// A row tick's pixel is registered and reaches the result port in the cycle after acceptance.
// Throughput: row ticks go at one per cycle while the result side does not stall.
// A column setup stalls the input through two passes of the shared one-bit-per-cycle divider
// and the final multiply that seeds the texture position.
// Reset (synchronous, active high) clears the controller, the column and result
// valid flags and both colour registers.
`default_nettype none

module textured_wall_column_generator_unit #(
   parameter int SCREEN_HEIGHT = 512
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_index,
   input  wire logic [31:0]                 csr_wr_data,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire twcg_pkg::req_kind_type      req_type,
   input  wire logic [twcg_pkg::ColW-1:0]    req_column_x,
   input  wire logic [twcg_pkg::DistW-1:0]   req_wall_distance,
   input  wire logic [twcg_pkg::TexColW-1:0] req_tex_column,
   input  wire logic [twcg_pkg::TexWidW-1:0] req_tex_width,
   input  wire logic [twcg_pkg::Log2W-1:0]   req_tex_height_log2,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [twcg_pkg::ColW-1:0]         rsp_pixel_x,
   output logic [twcg_pkg::RowW-1:0]         rsp_pixel_y,
   output logic [1:0]                       rsp_source,
   output logic [twcg_pkg::ColorW-1:0]       rsp_flat_color,
   output logic [twcg_pkg::IndexW-1:0]       rsp_texel_index,
   output logic                             rsp_last
);
   import twcg_pkg::*;

   // Divider width covers both height << 16 and the texture step numerator
   localparam int HeightNumW = $clog2(SCREEN_HEIGHT + 1) + FracW;
   localparam int DivW       = (HeightNumW > StepNumW) ? HeightNumW : StepNumW;

   dp_cmd_type    cmd;
   dp_status_type status;

   twcg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   twcg_dp #(
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .DIV_W         (DivW)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_column_x        (req_column_x),
      .req_wall_distance   (req_wall_distance),
      .req_tex_column      (req_tex_column),
      .req_tex_width       (req_tex_width),
      .req_tex_height_log2 (req_tex_height_log2),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pixel_x         (rsp_pixel_x),
      .rsp_pixel_y         (rsp_pixel_y),
      .rsp_source          (rsp_source),
      .rsp_flat_color      (rsp_flat_color),
      .rsp_texel_index     (rsp_texel_index),
      .rsp_last            (rsp_last)
   );

endmodule

`default_nettype wire

@@ verif/textured_wall_column_generator_unit_tb.sv @@
// Self-checking testbench for the textured wall column generator: directed and random beats.
`default_nettype none

module textured_wall_column_generator_unit_tb;
   import twcg_pkg::*;

   localparam int ScreenH      = 512;
   localparam int Half         = ScreenH / 2;
   localparam int SettleCycles = 100;        // covers the two divider passes of a setup
   localparam int PhaseItems   = 475;
   localparam int NumPhases    = 4;
   localparam int RunLimit     = 5_000_000;  // time units, well above the slowest run

   typedef struct packed {
      req_kind_type        kind;
      logic [ColW-1:0]     column_x;
      logic [DistW-1:0]    wall_distance;
      logic [TexColW-1:0]  tex_column;
      logic [TexWidW-1:0]  tex_width;
      logic [Log2W-1:0]    tex_height_log2;
   } req_beat_type;

   typedef struct packed {
      logic [ColW-1:0]     pixel_x;
      logic [RowW-1:0]     pixel_y;
      source_type          source;
      logic [ColorW-1:0]   flat_color;
      logic [IndexW-1:0]   texel_index;
      logic                last;
   } pixel_type;

   typedef struct {
      req_beat_type beat;
      bit           typed;
      bit           typed_has;
      pixel_type    typed_px;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   csr_index_type       csr_index;
   logic [31:0]         csr_wr_data;
   logic                req_valid;
   logic                req_stall;
   req_kind_type        req_type;
   logic [ColW-1:0]     req_column_x;
   logic [DistW-1:0]    req_wall_distance;
   logic [TexColW-1:0]  req_tex_column;
   logic [TexWidW-1:0]  req_tex_width;
   logic [Log2W-1:0]    req_tex_height_log2;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [ColW-1:0]     rsp_pixel_x;
   logic [RowW-1:0]     rsp_pixel_y;
   logic [1:0]          rsp_source;
   logic [ColorW-1:0]   rsp_flat_color;
   logic [IndexW-1:0]   rsp_texel_index;
   logic                rsp_last;

   // Column predictor state
   bit                  col_active;
   logic [RowW-1:0]     row_count;
   logic [RowW-1:0]     top_row;
   logic [BotW-1:0]     bottom_row;
   logic [PosW-1:0]     tex_pos;
   logic [PosW-1:0]     tex_step;
   logic [ColW-1:0]     held_col;
   logic [TexColW-1:0]  held_tc;
   logic [TexWidW-1:0]  held_tw;
   logic [Log2W-1:0]    held_log2;
   logic [ColorW-1:0]   ceil_rgba;
   logic [ColorW-1:0]   floor_rgba;

   pixel_type           pending_pixels[$];
   stim_row_type        stim_rows[$];
   int                  errors = 0;
   int                  burst_left = 0;
   int                  stall_left = 0;
   int                  stall_mode = 0;
   bit                  stall_toggle = 1'b0;

   textured_wall_column_generator_unit #(
      .SCREEN_HEIGHT(ScreenH)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_column_x        (req_column_x),
      .req_wall_distance   (req_wall_distance),
      .req_tex_column      (req_tex_column),
      .req_tex_width       (req_tex_width),
      .req_tex_height_log2 (req_tex_height_log2),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pixel_x         (rsp_pixel_x),
      .rsp_pixel_y         (rsp_pixel_y),
      .rsp_source          (rsp_source),
      .rsp_flat_color      (rsp_flat_color),
      .rsp_texel_index     (rsp_texel_index),
      .rsp_last            (rsp_last)
   );

   // Clock: 10 units per period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the column model by one beat; return 1 when the beat yields a pixel
   function automatic bit step_column(input req_beat_type b, output pixel_type px);
      longint unsigned lh;
      longint unsigned lh_half;
      longint unsigned texh;
      longint unsigned divisor;
      longint unsigned offset;
      logic [31:0]     trow;
      logic [31:0]     wide_idx;
      px = '0;
      if (b.kind == REQ_SETUP) begin
         held_col  = b.column_x;
         held_tc   = b.tex_column;
         held_tw   = b.tex_width;
         held_log2 = (b.tex_height_log2 > MaxLog2) ? Log2W'(MaxLog2) : b.tex_height_log2;
         // Near distance stands for 0.1
         if (b.wall_distance < NearLimit)
            lh = ScreenH * NearScale;
         else
            lh = (64'(ScreenH) << FracW) / b.wall_distance;
         lh_half    = lh / 2;
         top_row    = (lh_half >= Half) ? '0 : RowW'(Half - lh_half);
         bottom_row = (Half + lh_half >= ScreenH) ? BotW'(ScreenH) : BotW'(Half + lh_half);
         texh       = 64'd1 << held_log2;
         divisor    = (lh == 0) ? 64'd1 : lh;
         tex_step   = PosW'((texh << FracW) / divisor);
         offset     = top_row + lh_half - Half;
         tex_pos    = PosW'(offset * tex_step);
         row_count  = '0;
         col_active = 1'b1;
         return 1'b0;
      end
      // Drop ticks while no column is open
      if (!col_active)
         return 1'b0;
      px.pixel_x = held_col;
      px.pixel_y = row_count;
      if (row_count >= top_row && row_count <= bottom_row) begin
         trow           = (tex_pos >> FracW) & ((32'd1 << held_log2) - 32'd1);
         wide_idx       = trow * held_tw + held_tc;
         px.source      = SRC_WALL;
         px.texel_index = wide_idx[IndexW-1:0];
         tex_pos        = tex_pos + tex_step;
      end else if (row_count < top_row) begin
         px.source     = SRC_CEILING;
         px.flat_color = ceil_rgba;
      end else begin
         px.source     = SRC_FLOOR;
         px.flat_color = floor_rgba;
      end
      px.last = (row_count == ScreenH - 1);
      if (row_count >= ScreenH - 1) begin
         col_active = 1'b0;
         row_count  = '0;
      end else begin
         row_count = row_count + 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic req_beat_type mk_setup(input int col, input logic [31:0] wall_dist,
                                             input int tc, input int tw, input int lg);
      req_beat_type b;
      b.kind            = REQ_SETUP;
      b.column_x        = ColW'(col);
      b.wall_distance   = wall_dist;
      b.tex_column      = TexColW'(tc);
      b.tex_width       = TexWidW'(tw);
      b.tex_height_log2 = Log2W'(lg);
      return b;
   endfunction

   // Tick beat; a noisy tick carries junk in the fields the block ignores
   function automatic req_beat_type mk_tick(input bit noisy);
      req_beat_type b;
      b      = noisy ? req_beat_type'({$urandom(), $urandom(), $urandom()}) : '0;
      b.kind = REQ_TICK;
      return b;
   endfunction

   function automatic req_beat_type random_setup();
      logic [31:0] raw_dist;
      int          tw;
      case ($urandom_range(0, 5))
         0: raw_dist = $urandom_range(0, 8);
         1: raw_dist = $urandom_range(7, 32'h0001_0000);
         2: raw_dist = $urandom_range(32'h0000_8000, 32'h0008_0000);
         3: raw_dist = $urandom();
         4: raw_dist = $urandom_range(32'h0100_0000, 32'h0300_0000);
         default: raw_dist = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF
                                                         : $urandom_range(0, 32);
      endcase
      tw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : (1 << $urandom_range(0, 8));
      return mk_setup($urandom_range(0, 2047), raw_dist, $urandom_range(0, 255), tw,
                      ($urandom_range(0, 4) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8));
   endfunction

   // Send one request beat in bursts with random gaps; predict at acceptance
   task automatic drive_request(input req_beat_type b, input bit use_typed, input bit typed_has,
                                input pixel_type typed_px, output bit produced);
      int        gap;
      pixel_type px;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_type            <= b.kind;
      req_column_x        <= b.column_x;
      req_wall_distance   <= b.wall_distance;
      req_tex_column      <= b.tex_column;
      req_tex_width       <= b.tex_width;
      req_tex_height_log2 <= b.tex_height_log2;
      req_valid           <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      produced = step_column(b, px);
      if (use_typed) begin
         if (typed_has)
            pending_pixels.push_back(typed_px);
      end else if (produced) begin
         pending_pixels.push_back(px);
      end
      @(negedge clock);
   endtask

   // Hold off requests until every pixel is back and the setup engine is quiet
   task automatic drain_pixels();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0)
         @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // Write both colour registers on consecutive edges
   task automatic set_colors(input logic [31:0] ceil_val, input logic [31:0] floor_val);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_CEILING;
      csr_wr_data <= ceil_val;
      @(negedge clock);
      csr_index   <= CSR_FLOOR;
      csr_wr_data <= floor_val;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
      ceil_rgba  = ceil_val;
      floor_rgba = floor_val;
   endtask

   // Receiver stall pattern: quiet, random, alternating or mostly stalled stretches
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      stall_toggle = ~stall_toggle;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 2) == 0);
         2:       rsp_stall <= stall_toggle;
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Check each accepted pixel beat against the oldest prediction
   always @(posedge clock) begin : pixel_check
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel beat: x=%0d y=%0d", rsp_pixel_x, rsp_pixel_y);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_x !== want.pixel_x) begin
               $error("pixel_x: expected %0d, actual %0d", want.pixel_x, rsp_pixel_x);
               errors++;
            end
            if (rsp_pixel_y !== want.pixel_y) begin
               $error("pixel_y: expected %0d, actual %0d", want.pixel_y, rsp_pixel_y);
               errors++;
            end
            if (rsp_source !== want.source) begin
               $error("source: expected %0d, actual %0d", want.source, rsp_source);
               errors++;
            end
            if (rsp_flat_color !== want.flat_color) begin
               $error("flat_color: expected %h, actual %h", want.flat_color, rsp_flat_color);
               errors++;
            end
            if (rsp_texel_index !== want.texel_index) begin
               $error("texel_index: expected %0d, actual %0d", want.texel_index,
                      rsp_texel_index);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // Hard stop if the run hangs
   initial begin
      #(RunLimit);
      $display("textured_wall_column_generator_unit regression: fail");
      $finish;
   end

   // Main sequence
   initial begin : main_seq
      pixel_type none;
      pixel_type row0_ceiling;
      pixel_type row1_ceiling;
      bit        produced;
      int        sent;
      int        ticks;

      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = CSR_CEILING;
      csr_wr_data         = '0;
      req_valid           = 1'b0;
      req_type            = REQ_SETUP;
      req_column_x        = '0;
      req_wall_distance   = '0;
      req_tex_column      = '0;
      req_tex_width       = '0;
      req_tex_height_log2 = '0;
      rsp_stall           = 1'b0;

      // Predictor matches the reset state
      col_active = 1'b0;
      row_count  = '0;
      top_row    = '0;
      bottom_row = '0;
      tex_pos    = '0;
      tex_step   = '0;
      held_col   = '0;
      held_tc    = '0;
      held_tw    = '0;
      held_log2  = '0;
      ceil_rgba  = '0;
      floor_rgba = '0;

      none         = '0;
      row0_ceiling = '{11'd0, 12'd0, SRC_CEILING, 32'd0, 16'd0, 1'b0};
      row1_ceiling = '{11'd0, 12'd1, SRC_CEILING, 32'd0, 16'd0, 1'b0};

      // Directed beats: idle tick, far wall, near limits, saturated log2, odd widths
      stim_rows.push_back('{mk_tick(1'b0), 1'b1, 1'b0, none});
      stim_rows.push_back('{mk_setup(0, 32'hFFFF_FFFF, 0, 1, 0), 1'b1, 1'b0, none});
      stim_rows.push_back('{mk_tick(1'b0), 1'b1, 1'b1, row0_ceiling});
      stim_rows.push_back('{mk_tick(1'b1), 1'b1, 1'b1, row1_ceiling});
      stim_rows.push_back('{mk_setup(2047, 32'd0, 255, 256, 15), 1'b0, 1'b0, none});
      stim_rows.push_back('{mk_tick(1'b0), 1'b0, 1'b0, none});
      stim_rows.push_back('{mk_tick(1'b1), 1'b0, 1'b0, none});
      stim_rows.push_back('{mk_tick(1'b0), 1'b0, 1'b0, none});
      stim_rows.push_back('{mk_setup(1024, 32'd6, 128, 0, 8), 1'b0, 1'b0, none});
      stim_rows.push_back('{mk_tick(1'b0), 1'b0, 1'b0, none});
      stim_rows.push_back('{mk_tick(1'b1), 1'b0, 1'b0, none});
      stim_rows.push_back('{mk_setup(1, 32'd7, 200, 511, 9), 1'b0, 1'b0, none});
      stim_rows.push_back('{mk_tick(1'b0), 1'b0, 1'b0, none});
      stim_rows.push_back('{mk_tick(1'b0), 1'b0, 1'b0, none});
      stim_rows.push_back('{mk_setup(640, 32'h0001_0000, 17, 64, 4), 1'b0, 1'b0, none});
      stim_rows.push_back('{mk_tick(1'b0), 1'b0, 1'b0, none});
      stim_rows.push_back('{mk_tick(1'b1), 1'b0, 1'b0, none});
      stim_rows.push_back('{mk_setup(3, 32'h0002_0000, 9, 32, 5), 1'b0, 1'b0, none});
      stim_rows.push_back('{mk_tick(1'b0), 1'b0, 1'b0, none});
      stim_rows.push_back('{mk_setup(77, 32'h0200_0000, 1, 256, 8), 1'b0, 1'b0, none});
      stim_rows.push_back('{mk_tick(1'b0), 1'b0, 1'b0, none});

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table
      foreach (stim_rows[i])
         drive_request(stim_rows[i].beat, stim_rows[i].typed, stim_rows[i].typed_has,
                       stim_rows[i].typed_px, produced);

      // Random columns, one colour setting per phase
      for (int phase = 0; phase < NumPhases; phase++) begin
         drain_pixels();
         case (phase)
            0:       set_colors(32'h0000_0000, 32'hFFFF_FFFF);
            1:       set_colors(32'hFFFF_FFFF, 32'h0000_0000);
            default: set_colors($urandom(), $urandom());
         endcase
         sent = 0;
         while (sent < PhaseItems) begin
            drive_request(random_setup(), 1'b0, 1'b0, none, produced);
            sent++;
            // Mostly short columns that get abandoned; now and then a full one
            ticks = ($urandom_range(0, 5) == 0) ? ScreenH + $urandom_range(0, 4)
                                                : $urandom_range(0, 150);
            for (int t = 0; t < ticks && sent < PhaseItems; t++) begin
               drive_request(mk_tick($urandom_range(0, 1)), 1'b0, 1'b0, none, produced);
               if (produced)
                  sent++;
            end
         end
      end

      drain_pixels();
      if (errors == 0)
         $display("textured_wall_column_generator_unit regression: pass");
      else
         $display("textured_wall_column_generator_unit regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
